// File: rtl/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the touch tap / swipe classifier
// transfer payloads, configuration view, event and direction codes
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int COORD_W    = 16;
    localparam int COUNT_W    = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int THR_SQ_W   = 2 * CFG_DATA_W;

    // default coordinate storage width
    localparam int COORD_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROTATED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 2'd3;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RST_WIDTH    = 16'd480;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT   = 16'd480;
    localparam logic [THR_SQ_W-1:0]   RST_THR_SQ   = 32'd2500;

    // event kinds
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_TAP   = 2'd1;
    localparam logic [1:0] EV_SWIPE = 2'd2;
    localparam logic [1:0] EV_BAD   = 2'd3;

    // swipe directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic               buffer_ready;
        logic [COUNT_W-1:0] touch_count;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic               clear_status;
        logic [1:0]         event_kind;
        logic [1:0]         swipe_dir;
        logic [COORD_W-1:0] event_x;
        logic [COORD_W-1:0] event_y;
    } t_out_item;

    typedef struct packed {
        logic                  rotated;
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
        logic [THR_SQ_W-1:0]   thr_sq;
    } t_cfg;

    // mirror a coordinate for a half-turn display, clamped at zero
    function automatic logic [COORD_W-1:0] mirror(
        input logic                  rot,
        input logic [COORD_W-1:0]    v,
        input logic [CFG_DATA_W-1:0] size
    );
        logic [COORD_W-1:0] res;
        if (!rot) begin
            res = v;
        end else if (size == '0 || v >= size) begin
            res = '0;
        end else begin
            res = size - v - 16'd1;
        end
        return res;
    endfunction

endpackage

// File: rtl/tts_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_cfg: configuration registers
// write-only register file, keeps the squared swipe threshold
// ----------------------------------------------------------------------------
module tts_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [tts_pkg::CFG_IDX_W-1:0]     i_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]    i_data,
    output tts_pkg::t_cfg                     o_cfg
);

    tts_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotated <= 1'b0;
            r_cfg.width   <= tts_pkg::RST_WIDTH;
            r_cfg.height  <= tts_pkg::RST_HEIGHT;
            r_cfg.thr_sq  <= tts_pkg::RST_THR_SQ;
        end else if (i_we) begin
            unique case (i_index)
                tts_pkg::REG_ROTATED:  r_cfg.rotated <= i_data[0];
                tts_pkg::REG_WIDTH:    r_cfg.width   <= i_data;
                tts_pkg::REG_HEIGHT:   r_cfg.height  <= i_data;
                tts_pkg::REG_MIN_DIST: r_cfg.thr_sq  <= tts_pkg::THR_SQ_W'(i_data)
                                                        * tts_pkg::THR_SQ_W'(i_data);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/tts_gesture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_gesture: touch tracking and gesture classification
// keeps the start point and running travel, classifies on release
// ----------------------------------------------------------------------------
module tts_gesture #(
    parameter int COORD_BITS = tts_pkg::COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  tts_pkg::t_in_item  i_item,
    input  tts_pkg::t_cfg      i_cfg,
    output tts_pkg::t_out_item o_res
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int CMP_W = tts_pkg::THR_SQ_W + 1;

    logic                  r_active;
    logic [COORD_BITS-1:0] r_start_x;
    logic [COORD_BITS-1:0] r_start_y;
    logic [COORD_BITS-1:0] r_adx;
    logic [COORD_BITS-1:0] r_ady;
    logic                  r_dx_pos;
    logic                  r_dy_pos;

    logic                  n_active;
    logic [COORD_BITS-1:0] n_start_x;
    logic [COORD_BITS-1:0] n_start_y;
    logic [COORD_BITS-1:0] n_adx;
    logic [COORD_BITS-1:0] n_ady;
    logic                  n_dx_pos;
    logic                  n_dy_pos;

    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] ref_x;
    logic [COORD_BITS-1:0] ref_y;
    logic [SQ_W-1:0]       sq_x;
    logic [SQ_W-1:0]       sq_y;
    logic [SQ_W:0]         dist_sq;
    logic                  is_tap;
    logic [1:0]            dir;
    logic                  touching;
    logic                  release_ev;

    assign px = i_item.point_x[COORD_BITS-1:0];
    assign py = i_item.point_y[COORD_BITS-1:0];

    assign touching   = i_item.buffer_ready && (i_item.touch_count != '0);
    assign release_ev = i_item.buffer_ready && (i_item.touch_count == '0) && r_active;

    // first point of a touch becomes its own reference
    assign ref_x = r_active ? r_start_x : px;
    assign ref_y = r_active ? r_start_y : py;

    always_comb begin
        n_active  = r_active;
        n_start_x = r_start_x;
        n_start_y = r_start_y;
        n_adx     = r_adx;
        n_ady     = r_ady;
        n_dx_pos  = r_dx_pos;
        n_dy_pos  = r_dy_pos;
        if (touching) begin
            n_active  = 1'b1;
            n_start_x = ref_x;
            n_start_y = ref_y;
            n_dx_pos  = px > ref_x;
            n_dy_pos  = py > ref_y;
            n_adx     = (px >= ref_x) ? px - ref_x : ref_x - px;
            n_ady     = (py >= ref_y) ? py - ref_y : ref_y - py;
        end else if (release_ev) begin
            n_active = 1'b0;
            n_adx    = '0;
            n_ady    = '0;
            n_dx_pos = 1'b0;
            n_dy_pos = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_adx     <= '0;
            r_ady     <= '0;
            r_dx_pos  <= 1'b0;
            r_dy_pos  <= 1'b0;
        end else if (i_advance) begin
            r_active  <= n_active;
            r_start_x <= n_start_x;
            r_start_y <= n_start_y;
            r_adx     <= n_adx;
            r_ady     <= n_ady;
            r_dx_pos  <= n_dx_pos;
            r_dy_pos  <= n_dy_pos;
        end
    end

    // squared travel against squared threshold
    assign sq_x    = SQ_W'(r_adx) * SQ_W'(r_adx);
    assign sq_y    = SQ_W'(r_ady) * SQ_W'(r_ady);
    assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
    assign is_tap  = CMP_W'(dist_sq) < {1'b0, i_cfg.thr_sq};

    always_comb begin
        if (r_adx > r_ady) begin
            dir = r_dx_pos ? tts_pkg::DIR_RIGHT : tts_pkg::DIR_LEFT;
        end else begin
            dir = r_dy_pos ? tts_pkg::DIR_DOWN : tts_pkg::DIR_UP;
        end
        // half turn swaps up/down and left/right
        dir[0] = dir[0] ^ i_cfg.rotated;
    end

    always_comb begin
        o_res              = '0;
        o_res.clear_status = i_item.buffer_ready;
        if (release_ev) begin
            o_res.event_kind = is_tap ? tts_pkg::EV_TAP : tts_pkg::EV_SWIPE;
            o_res.swipe_dir  = is_tap ? tts_pkg::DIR_UP : dir;
            o_res.event_x    = tts_pkg::mirror(i_cfg.rotated,
                                   tts_pkg::COORD_W'(r_start_x), i_cfg.width);
            o_res.event_y    = tts_pkg::mirror(i_cfg.rotated,
                                   tts_pkg::COORD_W'(r_start_y), i_cfg.height);
        end
    end

    // travel is cleared whenever no touch is in progress
    a_idle_no_travel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_adx == '0 && r_ady == '0 && !r_dx_pos && !r_dy_pos))
        else $error("travel left over without an active touch");

endmodule

// File: rtl/touch_tap_swipe_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_swipe_classifier: tap / swipe detection from touch polls
// one poll in, one result out; classification on release of the touch
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall / i_in_item, one poll per transfer
//   (buffer-ready flag, touch count, first point x and y)
//   output channel: o_out_valid / i_out_stall / o_out_item, exactly one
//   result per poll, in poll order (status clear, event kind, direction, point)
//   configuration: i_cfg_we / i_cfg_index / i_cfg_data, written while idle;
//   the threshold is squared as it is written
//   path: input register, then result register; the state update, the
//   squaring of the travel and the threshold compare lie between the two
//   throughput: one poll per cycle while the result is not stalled, as
//   all of that fits in the single step between the registers
//   stall: a stalled result holds; the input register still fills behind it,
//   and o_in_stall rises only when both registers are full
//   reset: synchronous, active low; clears both valid flags, the touch state
//   and sets the registers to no rotation, 480 x 480 and a 50 pixel threshold
// ----------------------------------------------------------------------------
module touch_tap_swipe_classifier #(
    parameter int COORD_BITS = tts_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // poll channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tts_pkg::t_in_item              i_in_item,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tts_pkg::t_out_item             o_out_item,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [tts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tts_pkg::t_cfg      cfg;
    tts_pkg::t_in_item  r_in;
    logic               r_in_valid;
    tts_pkg::t_out_item r_out;
    logic               r_out_valid;
    tts_pkg::t_out_item res;

    logic out_free;
    logic advance;
    logic in_xfer;

    // result register can take a new value when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    tts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    tts_gesture #(
        .COORD_BITS (COORD_BITS)
    ) u_gesture (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_res     (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // any event comes from a ready buffer, so it always asks for a clear
    a_event_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.event_kind != tts_pkg::EV_NONE)
            |-> o_out_item.clear_status)
        else $error("event reported without status clear");

    // direction is only meaningful on a swipe
    a_dir_swipe_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.event_kind != tts_pkg::EV_SWIPE)
            |-> o_out_item.swipe_dir == tts_pkg::DIR_UP)
        else $error("direction set on a non-swipe result");

    // no event fields without an event
    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.event_kind == tts_pkg::EV_NONE)
            |-> (o_out_item.event_x == '0 && o_out_item.event_y == '0))
        else $error("point reported without an event");

    // the reserved kind code never appears
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.event_kind != tts_pkg::EV_BAD)
        else $error("reserved event kind");

endmodule
